// ===== hdl/apcu_pkg.sv =====
// Shared opcodes, widths and pipeline control type for the ARGB pixel combine unit.
package apcu_pkg;

    localparam int CHAN_W   = 8;
    localparam int PIXEL_W  = 32;
    localparam int NUM_CHAN = PIXEL_W / CHAN_W;
    localparam int OP_W     = 3;
    localparam int WEIGHT_W = 9;
    localparam int PROD_W   = 16;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 9'd256;
    localparam logic [CHAN_W-1:0]   CHANNEL_MAX = 8'hff;

    localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
    localparam logic [OP_W-1:0] OP_MIN   = 3'd2;
    localparam logic [OP_W-1:0] OP_MAX   = 3'd3;
    localparam logic [OP_W-1:0] OP_MOD   = 3'd4;
    localparam logic [OP_W-1:0] OP_MIX   = 3'd5;
    localparam logic [OP_W-1:0] OP_BLEND = 3'd6;

    // Load enables for the per-channel stages
    typedef struct packed {
        logic en_b;
        logic en_c;
        logic en_d;
    } t_pipe_en;

endpackage

// ===== hdl/argb_pixel_combine_unit.sv =====
// Top level of the ARGB8888 pixel combine unit: input stage, channel lanes, flow control.
// Combines two ARGB8888 pixels channel by channel (add, subtract, min, max, modulate,
// weighted mix, source-alpha blend) and takes one item per clock unless stalled. An item
// passes four register stages (input register, multiply, sum, divide by 255 or 256 and
// select), and o_valid is the valid bit of the last. Each stage holds its item while the
// one ahead is full and stalled, so a stall on i_ready backs up stage by stage and empty
// stages still fill; o_ready is high whenever the first stage is empty or moving on.
module argb_pixel_combine_unit
    import apcu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [PIXEL_W-1:0]  i_first_pixel,
    input  logic [PIXEL_W-1:0]  i_second_pixel,
    input  logic [WEIGHT_W-1:0] i_mix_weight,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [PIXEL_W-1:0]  o_result_pixel
);

    logic                r_va, r_vb, r_vc, r_vd;
    logic [OP_W-1:0]     r_op_a;
    logic [PIXEL_W-1:0]  r_p1_a, r_p2_a;
    logic [WEIGHT_W-1:0] r_w_a;

    logic     en_a;
    t_pipe_en pipe_en;

    // Advance a stage when it is empty or the stage ahead advances
    assign pipe_en.en_d = !r_vd || i_ready;
    assign pipe_en.en_c = !r_vc || pipe_en.en_d;
    assign pipe_en.en_b = !r_vb || pipe_en.en_c;
    assign en_a         = !r_va || pipe_en.en_b;
    assign o_ready      = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (en_a)         r_va <= i_valid;
            if (pipe_en.en_b) r_vb <= r_va;
            if (pipe_en.en_c) r_vc <= r_vb;
            if (pipe_en.en_d) r_vd <= r_vc;
        end
    end

    // Saturate weights above one on the way in
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_op_a <= i_opcode;
            r_p1_a <= i_first_pixel;
            r_p2_a <= i_second_pixel;
            r_w_a  <= (i_mix_weight > WEIGHT_ONE) ? WEIGHT_ONE : i_mix_weight;
        end
    end

    for (genvar k = 0; k < NUM_CHAN; k++) begin : g_chan
        apcu_chan u_chan (
            .i_clk (i_clk),
            .i_en  (pipe_en),
            .i_op  (r_op_a),
            .i_c1  (r_p1_a[k*CHAN_W +: CHAN_W]),
            .i_c2  (r_p2_a[k*CHAN_W +: CHAN_W]),
            .i_w   (r_w_a),
            .i_a1  (r_p1_a[PIXEL_W-1 -: CHAN_W]),
            .o_res (o_result_pixel[k*CHAN_W +: CHAN_W])
        );
    end

    assign o_valid = r_vd;

endmodule

// ===== hdl/apcu_chan.sv =====
// One 8-bit channel datapath: multiply, sum, divide by 255 or 256 and select.
module apcu_chan
    import apcu_pkg::*;
(
    input  logic                i_clk,
    input  t_pipe_en            i_en,
    input  logic [OP_W-1:0]     i_op,
    input  logic [CHAN_W-1:0]   i_c1,
    input  logic [CHAN_W-1:0]   i_c2,
    input  logic [WEIGHT_W-1:0] i_w,
    input  logic [CHAN_W-1:0]   i_a1,
    output logic [CHAN_W-1:0]   o_res
);

    logic [OP_W-1:0]     r_op_b, r_op_c;
    logic [PROD_W-1:0]   r_prod1_b, r_prod2_b, r_sum_c;
    logic [CHAN_W-1:0]   r_simple_b, r_simple_c, r_res_d;

    logic [WEIGHT_W-1:0] n_f1, n_f2;
    logic [CHAN_W-1:0]   n_simple;
    logic [CHAN_W:0]     add_sum;
    logic [PROD_W:0]     div_t;
    logic [CHAN_W-1:0]   n_res;

    assign add_sum = {1'b0, i_c1} + {1'b0, i_c2};

    // Stage B: pick multiplier factors and the result of the simple ops
    always_comb begin
        n_f1     = '0;
        n_f2     = '0;
        n_simple = i_c1;
        unique case (i_op)
            OP_ADD:   n_simple = add_sum[CHAN_W] ? CHANNEL_MAX : add_sum[CHAN_W-1:0];
            OP_SUB:   n_simple = (i_c1 > i_c2) ? (i_c1 - i_c2) : '0;
            OP_MIN:   n_simple = (i_c1 < i_c2) ? i_c1 : i_c2;
            OP_MAX:   n_simple = (i_c1 > i_c2) ? i_c1 : i_c2;
            OP_MOD: begin
                n_f1 = {1'b0, i_c2};
            end
            OP_MIX: begin
                n_f1 = i_w;
                n_f2 = WEIGHT_ONE - i_w;
            end
            OP_BLEND: begin
                n_f1 = {1'b0, i_a1};
                n_f2 = {1'b0, CHANNEL_MAX - i_a1};
            end
            default:  n_simple = i_c1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_b) begin
            r_op_b     <= i_op;
            r_simple_b <= n_simple;
            r_prod1_b  <= PROD_W'({8'd0, i_c1} * {7'd0, n_f1});
            r_prod2_b  <= PROD_W'({8'd0, i_c2} * {7'd0, n_f2});
        end
    end

    // Stage C: both products together never exceed 255 * 256
    always_ff @(posedge i_clk) begin
        if (i_en.en_c) begin
            r_op_c     <= r_op_b;
            r_simple_c <= r_simple_b;
            r_sum_c    <= r_prod1_b + r_prod2_b;
        end
    end

    // floor(x / 255) = (x + 1 + (x >> 8)) >> 8 for x up to 65534
    assign div_t = {1'b0, r_sum_c} + (PROD_W+1)'(1) + (PROD_W+1)'(r_sum_c >> CHAN_W);

    always_comb begin
        unique case (r_op_c)
            OP_MOD, OP_BLEND: n_res = div_t[PROD_W-1:CHAN_W];
            OP_MIX:           n_res = r_sum_c[PROD_W-1:CHAN_W];
            default:          n_res = r_simple_c;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_d) begin
            r_res_d <= n_res;
        end
    end

    assign o_res = r_res_d;

endmodule
